>>> rtl/nnts_pkg.sv
// Shared types and constants of the nearest-neighbor texture stretcher.
`default_nettype none
package nnts_pkg;

  localparam int DIM_W     = 13;  // texture and source side width
  localparam int COORD_W   = 12;  // destination column and row width
  localparam int FRAC_BITS = 16;  // fraction bits of the steps
  localparam int STEP_W    = 28;  // step (quotient) width
  localparam int ACC_W     = 30;  // accumulator width
  localparam int IDX_W     = 24;  // source index width
  localparam int SU_W      = ACC_W - FRAC_BITS;  // integer part of an accumulator
  localparam int PROD_W    = SU_W + DIM_W;
  localparam int CNT_W     = $clog2(STEP_W);
  localparam int CFG_IDX_W = 3;
  localparam int MAX_DIM   = 4096;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_POW2_ONLY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_ONLY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT  = 3'd5;

  localparam logic [DIM_W-1:0] MIN_SIDE_RESET = 13'd16;
  localparam logic [DIM_W-1:0] MAX_SIDE_RESET = 13'd1024;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // load a new texture, seed the dividers
    logic div_step;  // advance both dividers by one quotient bit
    logic pixel;     // emit one destination pixel and advance
    logic idle_rsp;  // emit an idle result
    logic out_load;  // load the output register
  } nnts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;      // current pixel is the final one of the texture
  } nnts_sts_t;

endpackage
`default_nettype wire

>>> rtl/nnts_ctrl.sv
// Controller of the texture stretcher: handshake, state machine, divider count.
`default_nettype none
module nnts_ctrl
  import nnts_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire logic      kind_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  input  wire nnts_sts_t sts_i,
  output nnts_cmd_t      cmd_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_RUN} state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               out_valid_q;
  logic               out_free;
  logic               accept;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q == ST_DIV) || !out_free;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.start    = accept && (kind_i == KIND_START);
    cmd_o.pixel    = accept && (kind_i == KIND_STEP) && (state_q == ST_RUN);
    cmd_o.idle_rsp = accept && (kind_i == KIND_STEP) && (state_q != ST_RUN);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.out_load = accept;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE, ST_RUN: begin
          if (cmd_o.start) begin
            state_q <= ST_DIV;
            cnt_q   <= '0;
          end else if (cmd_o.pixel && sts_i.last) begin
            state_q <= ST_IDLE;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(STEP_W - 1)) begin
            state_q <= ST_RUN;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_start_enters_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> (state_q == ST_DIV) && (cnt_q == '0))
    else $error("start did not enter the divide phase");

  a_div_ends_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) && (cnt_q == CNT_W'(STEP_W - 1)) |=> (state_q == ST_RUN))
    else $error("divide phase did not end after the last quotient bit");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted request produced no result");

  a_one_response: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.start, cmd_o.pixel, cmd_o.idle_rsp}))
    else $error("more than one response command at once");

endmodule
`default_nettype wire

>>> rtl/nnts_dp.sv
// Datapath of the texture stretcher: config, size adjust, dividers, walker, output register.
`default_nettype none
module nnts_dp
  import nnts_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DIM_W-1:0]     cfg_data_i,
  input  wire logic [DIM_W-1:0]     src_width_i,
  input  wire logic [DIM_W-1:0]     src_height_i,
  input  wire logic [DIM_W-1:0]     req_width_i,
  input  wire logic [DIM_W-1:0]     req_height_i,
  input  wire logic                 copy_mode_i,
  input  wire nnts_cmd_t            cmd_i,
  output nnts_sts_t                 sts_o,
  output logic                      is_size_report_o,
  output logic [DIM_W-1:0]          tex_width_o,
  output logic [DIM_W-1:0]          tex_height_o,
  output logic [IDX_W-1:0]          src_index_o,
  output logic [COORD_W-1:0]        dest_x_o,
  output logic [COORD_W-1:0]        dest_y_o,
  output logic                      in_source_o,
  output logic                      idle_o,
  output logic                      last_o
);

  localparam logic [DIM_W:0] ONE_W  = (DIM_W + 1)'(1);
  localparam logic [DIM_W:0] MAX_W  = (DIM_W + 1)'(MAX_DIM);

  function automatic logic [DIM_W:0] round_pow2(input logic [DIM_W-1:0] v);
    logic [DIM_W:0] r;
    logic [DIM_W:0] x;
    x = {1'b0, v};
    r = x;
    for (int i = 0; i < DIM_W; i++) begin
      if ((x > (ONE_W << i)) && (x <= (ONE_W << (i + 1)))) begin
        r = ONE_W << (i + 1);
      end
    end
    return r;
  endfunction

  function automatic logic [DIM_W:0] clamp_side(input logic [DIM_W:0] v,
                                                input logic [DIM_W-1:0] lo,
                                                input logic [DIM_W-1:0] hi);
    logic [DIM_W:0] r;
    r = v;
    if (v < {1'b0, lo}) begin
      r = {1'b0, lo};
    end else if (v > {1'b0, hi}) begin
      r = {1'b0, hi};
    end
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W:0] v);
    logic [DIM_W-1:0] r;
    r = v[DIM_W-1:0];
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > MAX_W) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  // Configuration registers.
  logic             pow2_only_q, square_only_q;
  logic [DIM_W-1:0] min_width_q, max_width_q, min_height_q, max_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pow2_only_q   <= 1'b0;
      square_only_q <= 1'b0;
      min_width_q   <= MIN_SIDE_RESET;
      max_width_q   <= MAX_SIDE_RESET;
      min_height_q  <= MIN_SIDE_RESET;
      max_height_q  <= MAX_SIDE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POW2_ONLY:   pow2_only_q   <= cfg_data_i[0];
        CFG_SQUARE_ONLY: square_only_q <= cfg_data_i[0];
        CFG_MIN_WIDTH:   min_width_q   <= cfg_data_i;
        CFG_MAX_WIDTH:   max_width_q   <= cfg_data_i;
        CFG_MIN_HEIGHT:  min_height_q  <= cfg_data_i;
        CFG_MAX_HEIGHT:  max_height_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Size adjustment of a start request.
  logic [DIM_W:0]   tw_p, th_p, tw_c, th_c, side_max;
  logic [DIM_W-1:0] tw_new, th_new, sw_new, sh_new, sw_m1, sh_m1;

  always_comb begin
    tw_p = pow2_only_q ? round_pow2(req_width_i)  : {1'b0, req_width_i};
    th_p = pow2_only_q ? round_pow2(req_height_i) : {1'b0, req_height_i};
    tw_c = clamp_side(tw_p, min_width_q, max_width_q);
    th_c = clamp_side(th_p, min_height_q, max_height_q);
    side_max = (tw_c > th_c) ? tw_c : th_c;
    if (square_only_q) begin
      tw_c = side_max;
      th_c = side_max;
    end
    tw_new = sat_dim(tw_c);
    th_new = sat_dim(th_c);
    sw_new = sat_dim({1'b0, src_width_i});
    sh_new = sat_dim({1'b0, src_height_i});
    sw_m1  = sw_new - DIM_W'(1);
    sh_m1  = sh_new - DIM_W'(1);
  end

  // Texture state.
  logic               mode_copy_q;
  logic [DIM_W-1:0]   tex_w_q, tex_h_q, src_w_q, src_h_q;
  logic [ACC_W-1:0]   acc_u_q, acc_v_q;
  logic [COORD_W-1:0] col_q, row_q;
  // Restoring dividers: dividend shifts out as the quotient shifts in.
  logic [STEP_W-1:0]  quo_u_q, quo_v_q;
  logic [DIM_W-1:0]   rem_u_q, rem_v_q;

  logic [DIM_W:0]     trial_u, trial_v;
  logic               ge_u, ge_v;

  always_comb begin
    trial_u = {rem_u_q, quo_u_q[STEP_W-1]};
    trial_v = {rem_v_q, quo_v_q[STEP_W-1]};
    ge_u    = trial_u >= {1'b0, tex_w_q};
    ge_v    = trial_v >= {1'b0, tex_h_q};
  end

  // Pixel generation.
  logic [DIM_W:0]     col_p1, row_p1;
  logic               row_end, is_last, in_src;
  logic [SU_W-1:0]    mul_a, mul_c;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W:0]    sum;
  logic [IDX_W-1:0]   idx;

  always_comb begin
    col_p1  = {2'b0, col_q} + (DIM_W + 1)'(1);
    row_p1  = {2'b0, row_q} + (DIM_W + 1)'(1);
    row_end = col_p1 >= {1'b0, tex_w_q};
    is_last = row_end && (row_p1 >= {1'b0, tex_h_q});
    in_src  = !mode_copy_q ||
              (({1'b0, col_q} < src_w_q) && ({1'b0, row_q} < src_h_q));
    mul_a   = mode_copy_q ? SU_W'(row_q) : acc_v_q[ACC_W-1:FRAC_BITS];
    mul_c   = mode_copy_q ? SU_W'(col_q) : acc_u_q[ACC_W-1:FRAC_BITS];
    prod    = PROD_W'(mul_a) * PROD_W'(src_w_q);
    sum     = {1'b0, prod} + (PROD_W + 1)'(mul_c);
    idx     = in_src ? sum[IDX_W-1:0] : '0;
  end

  assign sts_o.last = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_copy_q <= 1'b0;
      tex_w_q     <= '0;
      tex_h_q     <= '0;
      src_w_q     <= '0;
      src_h_q     <= '0;
      acc_u_q     <= '0;
      acc_v_q     <= '0;
      col_q       <= '0;
      row_q       <= '0;
      quo_u_q     <= '0;
      quo_v_q     <= '0;
      rem_u_q     <= '0;
      rem_v_q     <= '0;
    end else if (cmd_i.start) begin
      mode_copy_q <= copy_mode_i;
      tex_w_q     <= tw_new;
      tex_h_q     <= th_new;
      src_w_q     <= sw_new;
      src_h_q     <= sh_new;
      acc_u_q     <= '0;
      acc_v_q     <= '0;
      col_q       <= '0;
      row_q       <= '0;
      quo_u_q     <= {sw_m1[STEP_W-FRAC_BITS-1:0], FRAC_BITS'(0)};
      quo_v_q     <= {sh_m1[STEP_W-FRAC_BITS-1:0], FRAC_BITS'(0)};
      rem_u_q     <= '0;
      rem_v_q     <= '0;
    end else if (cmd_i.div_step) begin
      rem_u_q <= ge_u ? DIM_W'(trial_u - {1'b0, tex_w_q}) : trial_u[DIM_W-1:0];
      rem_v_q <= ge_v ? DIM_W'(trial_v - {1'b0, tex_h_q}) : trial_v[DIM_W-1:0];
      quo_u_q <= {quo_u_q[STEP_W-2:0], ge_u};
      quo_v_q <= {quo_v_q[STEP_W-2:0], ge_v};
    end else if (cmd_i.pixel) begin
      if (is_last) begin
        col_q   <= '0;
        row_q   <= '0;
        acc_u_q <= '0;
        acc_v_q <= '0;
      end else if (row_end) begin
        col_q   <= '0;
        acc_u_q <= '0;
        row_q   <= row_p1[COORD_W-1:0];
        acc_v_q <= acc_v_q + ACC_W'(quo_v_q);
      end else begin
        col_q   <= col_p1[COORD_W-1:0];
        acc_u_q <= acc_u_q + ACC_W'(quo_u_q);
      end
    end
  end

  // Output register; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      is_size_report_o <= cmd_i.start;
      tex_width_o      <= cmd_i.start ? tw_new : '0;
      tex_height_o     <= cmd_i.start ? th_new : '0;
      src_index_o      <= cmd_i.pixel ? idx : '0;
      dest_x_o         <= cmd_i.pixel ? col_q : '0;
      dest_y_o         <= cmd_i.pixel ? row_q : '0;
      in_source_o      <= cmd_i.pixel && in_src;
      idle_o           <= cmd_i.idle_rsp;
      last_o           <= cmd_i.pixel && is_last;
    end
  end

endmodule
`default_nettype wire

>>> rtl/nearest_neighbor_texture_stretch.sv
// Top level of the nearest-neighbor texture stretcher.
`default_nettype none
// A start request (kind 0) adjusts the requested texture size (optional
// power-of-two round up, clamp to the min/max registers with the minimum
// checked first, optional square to the larger side, saturate to 1..4096) and
// answers with a size report. It then computes the 12.16 steps
// ((src-1) << 16) / tex for both axes in two restoring dividers that share
// one bit counter: one quotient bit per cycle, with in_stall_o
// high throughout. Each step request (kind 1) then yields one destination
// pixel in row order, one per cycle unless the output register is stalled:
// in stretch mode the nearest-neighbor source index from the integer parts
// of the accumulators, in copy mode the direct index or in_source_o low for
// padding. last_o marks the final pixel, after which the block is idle
// again; a step while idle returns idle_o. A start while a texture runs
// abandons it. Results sit in one output register; while it is full and
// stalled, new requests are held off. Write the configuration registers
// only while the block is idle: they are sampled on start.
module nearest_neighbor_texture_stretch
  import nnts_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DIM_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 kind_i,
  input  wire logic [DIM_W-1:0]     src_width_i,
  input  wire logic [DIM_W-1:0]     src_height_i,
  input  wire logic [DIM_W-1:0]     req_width_i,
  input  wire logic [DIM_W-1:0]     req_height_i,
  input  wire logic                 copy_mode_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      is_size_report_o,
  output logic [DIM_W-1:0]          tex_width_o,
  output logic [DIM_W-1:0]          tex_height_o,
  output logic [IDX_W-1:0]          src_index_o,
  output logic [COORD_W-1:0]        dest_x_o,
  output logic [COORD_W-1:0]        dest_y_o,
  output logic                      in_source_o,
  output logic                      idle_o,
  output logic                      last_o
);

  nnts_cmd_t cmd;
  nnts_sts_t sts;

  // Sequence requests, run the divide phase, track the output register.
  nnts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hold configuration and texture state, divide, walk pixels, drive results.
  nnts_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .src_width_i      (src_width_i),
    .src_height_i     (src_height_i),
    .req_width_i      (req_width_i),
    .req_height_i     (req_height_i),
    .copy_mode_i      (copy_mode_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .is_size_report_o (is_size_report_o),
    .tex_width_o      (tex_width_o),
    .tex_height_o     (tex_height_o),
    .src_index_o      (src_index_o),
    .dest_x_o         (dest_x_o),
    .dest_y_o         (dest_y_o),
    .in_source_o      (in_source_o),
    .idle_o           (idle_o),
    .last_o           (last_o)
  );

endmodule
`default_nettype wire

>>> tb/nnts_texel_checker.sv
// Checker for the texture stretcher: predicts every result and compares it.
module nnts_texel_checker
  import nnts_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic                 kind_i,
  input  logic [DIM_W-1:0]     src_width_i,
  input  logic [DIM_W-1:0]     src_height_i,
  input  logic [DIM_W-1:0]     req_width_i,
  input  logic [DIM_W-1:0]     req_height_i,
  input  logic                 copy_mode_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic                 is_size_report_i,
  input  logic [DIM_W-1:0]     tex_width_i,
  input  logic [DIM_W-1:0]     tex_height_i,
  input  logic [IDX_W-1:0]     src_index_i,
  input  logic [COORD_W-1:0]   dest_x_i,
  input  logic [COORD_W-1:0]   dest_y_i,
  input  logic                 in_source_i,
  input  logic                 idle_i,
  input  logic                 last_i,
  output int unsigned          fail_count_o,
  output int unsigned          awaited_o
);

  typedef struct packed {
    logic               is_size_report;
    logic [DIM_W-1:0]   tex_width;
    logic [DIM_W-1:0]   tex_height;
    logic [IDX_W-1:0]   src_index;
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
    logic               in_source;
    logic               idle;
    logic               last;
  } texel_rsp_t;

  localparam longint ACC_MASK = 64'h3FFF_FFFF;
  localparam int     COORD_MASK = 'hFFF;

  texel_rsp_t texel_q[$];

  // Register copy.
  logic pow2_en, square_en;
  int   min_w, max_w, min_h, max_h;

  // Walk state.
  logic   walking, copy_walk;
  int     tex_w, tex_h, src_w, src_h;
  longint step_u, step_v, acc_u, acc_v;
  int     col, row;

  function automatic int ceil_pow2(int v);
    for (int i = 0; i < 16; i++) begin
      if (v > (1 << i) && v <= (2 << i)) return 2 << i;
    end
    return v;
  endfunction

  function automatic int clamp_side(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int sat_side(int v);
    if (v < 1) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic string show(texel_rsp_t t);
    return $sformatf("rpt=%0d tw=%0d th=%0d idx=%0d x=%0d y=%0d src=%0d idle=%0d last=%0d",
                     t.is_size_report, t.tex_width, t.tex_height, t.src_index,
                     t.dest_x, t.dest_y, t.in_source, t.idle, t.last);
  endfunction

  // Advance the stretcher by one request and return the result it owes.
  function automatic texel_rsp_t stretch_request(logic kind, int sw, int sh, int rw, int rh,
                                                 logic copy);
    texel_rsp_t r;
    int         tw, th, m;
    longint     idx;
    logic       at_end;
    r = '0;
    if (kind == KIND_START) begin
      tw = rw;
      th = rh;
      if (pow2_en) begin
        tw = ceil_pow2(tw);
        th = ceil_pow2(th);
      end
      tw = clamp_side(tw, min_w, max_w);
      th = clamp_side(th, min_h, max_h);
      if (square_en) begin
        m  = (tw > th) ? tw : th;
        tw = m;
        th = m;
      end
      tw        = sat_side(tw);
      th        = sat_side(th);
      tex_w     = tw;
      tex_h     = th;
      src_w     = sat_side(sw);
      src_h     = sat_side(sh);
      copy_walk = copy;
      step_u    = (longint'(src_w - 1) << FRAC_BITS) / tw;
      step_v    = (longint'(src_h - 1) << FRAC_BITS) / th;
      acc_u     = 0;
      acc_v     = 0;
      col       = 0;
      row       = 0;
      walking   = 1'b1;
      r.is_size_report = 1'b1;
      r.tex_width      = tw[DIM_W-1:0];
      r.tex_height     = th[DIM_W-1:0];
      return r;
    end
    if (!walking) begin
      r.idle = 1'b1;
      return r;
    end
    r.in_source = 1'b1;
    if (copy_walk) begin
      if (col < src_w && row < src_h) begin
        idx = longint'(row) * src_w + col;
      end else begin
        idx         = 0;
        r.in_source = 1'b0;
      end
    end else begin
      idx = (acc_v >> FRAC_BITS) * src_w + (acc_u >> FRAC_BITS);
    end
    at_end      = (col + 1 >= tex_w) && (row + 1 >= tex_h);
    r.src_index = idx[IDX_W-1:0];
    r.dest_x    = col[COORD_W-1:0];
    r.dest_y    = row[COORD_W-1:0];
    r.last      = at_end;
    if (at_end) begin
      walking = 1'b0;
      col     = 0;
      row     = 0;
      acc_u   = 0;
      acc_v   = 0;
    end else if (col + 1 >= tex_w) begin
      col   = 0;
      acc_u = 0;
      row   = (row + 1) & COORD_MASK;
      acc_v = (acc_v + step_v) & ACC_MASK;
    end else begin
      col   = (col + 1) & COORD_MASK;
      acc_u = (acc_u + step_u) & ACC_MASK;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    texel_rsp_t seen, want;
    if (!rst_ni) begin
      pow2_en      = 1'b0;
      square_en    = 1'b0;
      min_w        = MIN_SIDE_RESET;
      max_w        = MAX_SIDE_RESET;
      min_h        = MIN_SIDE_RESET;
      max_h        = MAX_SIDE_RESET;
      walking      = 1'b0;
      copy_walk    = 1'b0;
      tex_w        = 0;
      tex_h        = 0;
      src_w        = 0;
      src_h        = 0;
      step_u       = 0;
      step_v       = 0;
      acc_u        = 0;
      acc_v        = 0;
      col          = 0;
      row          = 0;
      fail_count_o = 0;
      texel_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_POW2_ONLY:   pow2_en   = cfg_data_i[0];
          CFG_SQUARE_ONLY: square_en = cfg_data_i[0];
          CFG_MIN_WIDTH:   min_w     = cfg_data_i;
          CFG_MAX_WIDTH:   max_w     = cfg_data_i;
          CFG_MIN_HEIGHT:  min_h     = cfg_data_i;
          CFG_MAX_HEIGHT:  max_h     = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        texel_q.push_back(stretch_request(kind_i, src_width_i, src_height_i,
                                          req_width_i, req_height_i, copy_mode_i));
      end
      if (out_valid_i && !out_stall_i) begin
        seen = {is_size_report_i, tex_width_i, tex_height_i, src_index_i,
                dest_x_i, dest_y_i, in_source_i, idle_i, last_i};
        if (texel_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: result with no request pending: %s", $realtime, show(seen));
        end else begin
          want = texel_q.pop_front();
          if (seen != want) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("%0t: texel mismatch", $realtime);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(seen));
            end
          end
        end
      end
    end
    awaited_o = texel_q.size();
  end

endmodule

>>> tb/nearest_neighbor_texture_stretch_test.sv
// Stimulus and verdict for the nearest-neighbor texture stretcher.
module nearest_neighbor_texture_stretch_test;
  import nnts_pkg::*;

  // Slowest run: every request may wait out a full divide phase plus a sender
  // gap and a receiver stall, plus the pauses between phases.
  // Allow several times that.
  localparam int CYCLE_LIMIT  = 400000;
  // A start keeps the block busy through the divide phase; let that pass
  // with margin before touching the registers or ending the run.
  localparam int DRAIN_CYCLES = 64;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DIM_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 kind_i;
  logic [DIM_W-1:0]     src_width_i;
  logic [DIM_W-1:0]     src_height_i;
  logic [DIM_W-1:0]     req_width_i;
  logic [DIM_W-1:0]     req_height_i;
  logic                 copy_mode_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 is_size_report_o;
  logic [DIM_W-1:0]     tex_width_o;
  logic [DIM_W-1:0]     tex_height_o;
  logic [IDX_W-1:0]     src_index_o;
  logic [COORD_W-1:0]   dest_x_o;
  logic [COORD_W-1:0]   dest_y_o;
  logic                 in_source_o;
  logic                 idle_o;
  logic                 last_o;

  int unsigned fail_count;
  int unsigned awaited;
  int unsigned cycle_cnt = 0;
  bit          churn = 1'b0;  // random idling on both channels

  nearest_neighbor_texture_stretch u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .src_width_i      (src_width_i),
    .src_height_i     (src_height_i),
    .req_width_i      (req_width_i),
    .req_height_i     (req_height_i),
    .copy_mode_i      (copy_mode_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .is_size_report_o (is_size_report_o),
    .tex_width_o      (tex_width_o),
    .tex_height_o     (tex_height_o),
    .src_index_o      (src_index_o),
    .dest_x_o         (dest_x_o),
    .dest_y_o         (dest_y_o),
    .in_source_o      (in_source_o),
    .idle_o           (idle_o),
    .last_o           (last_o)
  );

  nnts_texel_checker u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .kind_i           (kind_i),
    .src_width_i      (src_width_i),
    .src_height_i     (src_height_i),
    .req_width_i      (req_width_i),
    .req_height_i     (req_height_i),
    .copy_mode_i      (copy_mode_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .is_size_report_i (is_size_report_o),
    .tex_width_i      (tex_width_o),
    .tex_height_i     (tex_height_o),
    .src_index_i      (src_index_o),
    .dest_x_i         (dest_x_o),
    .dest_y_i         (dest_y_o),
    .in_source_i      (in_source_o),
    .idle_i           (idle_o),
    .last_i           (last_o),
    .fail_count_o     (fail_count),
    .awaited_o        (awaited)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: stall the result channel in random bursts while churn is on.
  initial begin : result_stall
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (churn && $urandom_range(0, 7) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  // Present one request at a falling edge and hold it until the block takes
  // it. Valid stays high afterwards so back-to-back requests need no gap.
  task automatic send_request(logic kind, logic [DIM_W-1:0] sw, logic [DIM_W-1:0] sh,
                              logic [DIM_W-1:0] rw, logic [DIM_W-1:0] rh, logic copy);
    if (churn && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    kind_i       = kind;
    src_width_i  = sw;
    src_height_i = sh;
    req_width_i  = rw;
    req_height_i = rh;
    copy_mode_i  = copy;
    in_valid_i   = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Step payload is ignored by the block; scramble it anyway.
  task automatic step_pixel();
    send_request(KIND_STEP, $urandom_range(0, 8191), $urandom_range(0, 8191),
                 $urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(0, 1));
  endtask

  // Drop valid, wait for every outstanding result, then let the divider
  // finish before the caller touches the registers.
  task automatic drain();
    in_valid_i = 1'b0;
    while (awaited != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
    cfg_idx_i  = idx;
    cfg_data_i = data;
    cfg_we_i   = 1'b1;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  task automatic load_setup(logic pow2, logic square, int minw, int maxw, int minh, int maxh);
    drain();
    write_reg(CFG_POW2_ONLY, pow2);
    write_reg(CFG_SQUARE_ONLY, square);
    write_reg(CFG_MIN_WIDTH, minw);
    write_reg(CFG_MAX_WIDTH, maxw);
    write_reg(CFG_MIN_HEIGHT, minh);
    write_reg(CFG_MAX_HEIGHT, maxh);
  endtask

  // Mostly small sides so textures finish; now and then the full range.
  function automatic logic [DIM_W-1:0] pick_side();
    if ($urandom_range(0, 7) == 0) return $urandom_range(1, MAX_DIM);
    return $urandom_range(1, 12);
  endfunction

  // Mostly well-formed textures (start, then a run of steps that often ends
  // at the last pixel or beyond it); the rest stray steps and wild starts.
  task automatic random_phase(int count);
    int          issued;
    int          n;
    int unsigned pick;
    issued = 0;
    while (issued < count) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        send_request(KIND_START, pick_side(), pick_side(), pick_side(), pick_side(),
                     $urandom_range(0, 1));
        n = $urandom_range(1, 70);
        repeat (n) step_pixel();
        issued += n + 1;
      end else if (pick == 8) begin
        step_pixel();
        issued++;
      end else begin
        send_request(KIND_START, $urandom_range(0, 8191), $urandom_range(0, 8191),
                     $urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(0, 1));
        issued++;
      end
    end
  endtask

  initial begin : stimulus
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_POW2_ONLY;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    kind_i       = KIND_STEP;
    src_width_i  = '0;
    src_height_i = '0;
    req_width_i  = '0;
    req_height_i = '0;
    copy_mode_i  = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    churn  = 1'b1;

    // Directed part under the reset register values.
    step_pixel();                                          // step while idle
    send_request(KIND_START, 4096, 4096, 4096, 4096, 1'b0);  // clamp to max
    repeat (3) step_pixel();
    send_request(KIND_START, 1, 1, 1, 1, 1'b1);            // abandon, copy with pad
    repeat (2) step_pixel();
    send_request(KIND_START, 0, 8191, 0, 8191, 1'b0);      // degenerate source sides
    repeat (2) step_pixel();
    send_request(KIND_START, 4095, 4095, 17, 4095, 1'b1);  // source beyond texture
    repeat (2) step_pixel();
    send_request(KIND_START, 2730, 5, 20, 16, 1'b0);
    repeat (2) step_pixel();
    send_request(KIND_START, 1365, 4096, 1024, 1025, 1'b1);
    step_pixel();

    // Hold off until every result is back before the random part.
    drain();

    load_setup(1'b0, 1'b0, 1, 8, 1, 8);
    random_phase(75);
    load_setup(1'b1, 1'b0, 1, 8, 1, 4);
    random_phase(75);
    churn = 1'b0;
    load_setup(1'b0, 1'b1, 1, 6, 1, 8);
    random_phase(75);
    churn = 1'b1;
    load_setup(1'b1, 1'b1, 2, 5, 1, 3);
    random_phase(75);
    load_setup(1'b0, 1'b0, 5, 3, 4, 2);                    // minimum above maximum
    random_phase(75);
    load_setup(1'b0, 1'b0, 4096, 4096, 1, 1);
    random_phase(75);
    load_setup(1'b1, 1'b0, 1, 4096, 4096, 4096);
    random_phase(75);

    // Final stretch without any idling.
    churn = 1'b0;
    load_setup(1'b0, 1'b0, 1, 4, 1, 4);
    random_phase(75);

    drain();
    if (fail_count == 0 && awaited == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/nnts_pkg.sv
rtl/nnts_ctrl.sv
rtl/nnts_dp.sv
rtl/nearest_neighbor_texture_stretch.sv
tb/nnts_texel_checker.sv
tb/nearest_neighbor_texture_stretch_test.sv
